>>> hdl/bft_pkg.sv
// Shared widths and types for the bit fingerprint Tanimoto block.
package bft_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PopW     = 4;   // popcount of one byte, 0..8
  localparam int unsigned CntW     = 11;  // saturating bit counts
  localparam int unsigned UniW     = 12;  // first + second - both
  localparam int unsigned SimW     = 17;  // Q1.16 ratio
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutPadW  = OutDataW - SimW - CntW;
  localparam int unsigned CntMax   = 2047;

  // Final counts of one fingerprint pair, handed from front to back.
  typedef struct packed {
    logic [CntW-1:0] both;
    logic [CntW-1:0] first;
    logic [CntW-1:0] second;
  } counts_t;

endpackage

>>> hdl/bft_front.sv
// Front end: accept byte pairs, accumulate saturating popcounts, queue finished pairs.
module bft_front #(
  parameter int unsigned MAX_BYTES = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bft_pkg::ByteW-1:0]     byte_a_i,
  input  logic [bft_pkg::ByteW-1:0]     byte_b_i,
  input  logic                          last_byte_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output bft_pkg::counts_t              q_data_o
);

  localparam int unsigned CapRaw = 8 * MAX_BYTES;
  localparam int unsigned Cap    = (CapRaw < bft_pkg::CntMax) ? CapRaw : bft_pkg::CntMax;
  localparam logic [bft_pkg::CntW:0] CapV = (bft_pkg::CntW + 1)'(Cap);

  function automatic logic [bft_pkg::PopW-1:0] pop8(input logic [bft_pkg::ByteW-1:0] v);
    logic [bft_pkg::PopW-1:0] n;
    n = '0;
    for (int k = 0; k < bft_pkg::ByteW; k++) begin
      n = n + bft_pkg::PopW'(v[k]);
    end
    return n;
  endfunction

  function automatic logic [bft_pkg::CntW-1:0] add_sat(input logic [bft_pkg::CntW-1:0] acc,
                                                       input logic [bft_pkg::PopW-1:0] inc);
    logic [bft_pkg::CntW:0] s;
    s = {1'b0, acc} + (bft_pkg::CntW + 1)'(inc);
    return (s > CapV) ? CapV[bft_pkg::CntW-1:0] : s[bft_pkg::CntW-1:0];
  endfunction

  bft_pkg::counts_t cnt_q, cnt_d, cnt_sum;
  logic             fire;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    cnt_sum.both   = add_sat(cnt_q.both, pop8(byte_a_i & byte_b_i));
    cnt_sum.first  = add_sat(cnt_q.first, pop8(byte_a_i));
    cnt_sum.second = add_sat(cnt_q.second, pop8(byte_b_i));
    cnt_d = cnt_q;
    if (fire) begin
      cnt_d = last_byte_i ? '0 : cnt_sum;
    end
  end

  assign q_push_o = fire && last_byte_i;
  assign q_data_o = cnt_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hdl/bft_fifo.sv
// Two-entry queue of finished pair counts between front and back.
module bft_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bft_pkg::counts_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             rd_valid_o,
  output bft_pkg::counts_t rd_data_o
);

  bft_pkg::counts_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q, fill_d;

  assign full_o     = fill_q[1];
  assign rd_valid_o = (fill_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fill_q <= fill_d;
    end
  end

endmodule

>>> hdl/bft_back.sv
// Back end: restoring divider for the Tanimoto ratio and the result register.
module bft_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  bft_pkg::counts_t            q_data_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bft_pkg::SimW-1:0]    similarity_o,
  output logic [bft_pkg::CntW-1:0]    common_bits_o,
  output logic                        empty_pair_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic [bft_pkg::UniW-1:0]  rem_q, rem_d, uni_q, uni_d;
  logic [bft_pkg::SimW-1:0]  quot_q, quot_d;
  logic [bft_pkg::CntW-1:0]  both_q, both_d;
  logic                      empty_q, empty_d;
  logic [3:0]                step_q, step_d;
  logic                      out_valid_q, out_valid_d, out_load;
  logic [bft_pkg::SimW-1:0]  out_sim_q;
  logic [bft_pkg::CntW-1:0]  out_common_q;
  logic                      out_empty_q;

  logic [bft_pkg::UniW-1:0]  uni_new, both_ext;
  logic                      ge_load, ge_step;
  logic [bft_pkg::UniW:0]    shifted;

  assign both_ext = {1'b0, q_data_i.both};
  assign uni_new  = {1'b0, q_data_i.first} + {1'b0, q_data_i.second} - both_ext;
  assign ge_load  = (both_ext >= uni_new);
  assign shifted  = {rem_q, 1'b0};
  assign ge_step  = (shifted >= {1'b0, uni_q});

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    uni_d    = uni_q;
    quot_d   = quot_q;
    both_d   = both_q;
    empty_d  = empty_q;
    step_d   = step_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          uni_d   = uni_new;
          both_d  = q_data_i.both;
          empty_d = (uni_new == '0);
          step_d  = 4'd15;
          if (uni_new == '0) begin
            quot_d  = '0;
            state_d = S_FIN;
          end else begin
            rem_d   = ge_load ? (both_ext - uni_new) : both_ext;
            quot_d  = bft_pkg::SimW'(ge_load);
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_d  = ge_step ? bft_pkg::UniW'(shifted - {1'b0, uni_q}) : shifted[bft_pkg::UniW-1:0];
        quot_d = {quot_q[bft_pkg::SimW-2:0], ge_step};
        step_d = step_q - 4'd1;
        if (step_q == 4'd0) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Hand over once the result register is free or draining.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign similarity_o  = out_sim_q;
  assign common_bits_o = out_common_q;
  assign empty_pair_o  = out_empty_q;

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    uni_q  <= uni_d;
    quot_q <= quot_d;
    both_q <= both_d;
    step_q <= step_d;
    if (out_load) begin
      out_sim_q    <= quot_q;
      out_common_q <= both_q;
      out_empty_q  <= empty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hdl/bit_fingerprint_tanimoto.sv
// Top level of the bit fingerprint Tanimoto similarity block.
//
// Usage: stream two fingerprints in lockstep on the slave side, one byte of
// each per transfer, with tlast on the final byte pair. For every transfer
// with tlast high one result transfer comes out on the master side:
// the ratio both/(first+second-both) in unsigned Q1.16 (65536 = identical),
// the count of common set bits, and tuser high when both fingerprints held
// no set bit (ratio and count are then zero).
// Throughput: one byte pair per cycle while the queue is not full. Each
// finished pair occupies the divider for a load step, 16 quotient bits one
// per cycle and a hand-over step, so pairs of 18 bytes or more stream at
// full rate; shorter ones are paced by the divider once the two-entry
// queue fills. A result goes through the queue, the load step, the divide
// steps and the hand-over; an all-zero pair skips the divide steps.
// Reset clears the running counts, the queue and the result valid flag.
// A stalled receiver holds the result; the divider finishes the next pair
// and waits, and the front keeps taking bytes until the queue is full.
module bit_fingerprint_tanimoto #(
  parameter int unsigned MAX_BYTES = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bft_pkg::InDataW-1:0]     s_axis_tdata,   // byte_a, byte_b
  input  logic                            s_axis_tlast,   // last_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bft_pkg::OutDataW-1:0]    m_axis_tdata,   // similarity, common_bits, zero pad
  output logic                            m_axis_tuser    // empty_pair
);

  logic                           q_full, q_push, q_pop, q_valid;
  bft_pkg::counts_t               q_wdata, q_rdata;
  logic [bft_pkg::SimW-1:0]       similarity;
  logic [bft_pkg::CntW-1:0]       common_bits;

  // Accumulate popcounts and push the totals on the last byte.
  bft_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .byte_a_i    (s_axis_tdata[7:0]),
    .byte_b_i    (s_axis_tdata[15:8]),
    .last_byte_i (s_axis_tlast),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // Decouple byte intake from the divider.
  bft_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .rd_valid_o  (q_valid),
    .rd_data_o   (q_rdata)
  );

  // Divide and hold the result until transferred.
  bft_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .similarity_o  (similarity),
    .common_bits_o (common_bits),
    .empty_pair_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {{bft_pkg::OutPadW{1'b0}}, common_bits, similarity};

endmodule

>>> hdl/bft_checker.sv
// Port-level checks of the Tanimoto block, bound to the top level.
module bft_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bft_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);

  localparam logic [bft_pkg::SimW-1:0] One = bft_pkg::SimW'(65536);

  logic [bft_pkg::SimW-1:0] sim;
  logic [bft_pkg::CntW-1:0] common;

  assign sim    = m_axis_tdata[bft_pkg::SimW-1:0];
  assign common = m_axis_tdata[bft_pkg::SimW+bft_pkg::CntW-1:bft_pkg::SimW];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> sim == '0 && common == '0)
    else $error("empty pair with nonzero result");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> sim <= One)
    else $error("ratio above one");

  a_one_needs_common: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && sim == One |-> common != '0 && !m_axis_tuser)
    else $error("ratio of one without common bits");

  a_no_common_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && common == '0 |-> sim == '0)
    else $error("nonzero ratio without common bits");

endmodule

bind bit_fingerprint_tanimoto bft_checker u_bft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/bft_tanimoto_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the fingerprint Tanimoto block: predicts every ratio and checks each result.
module bft_tanimoto_checker #(
  parameter int unsigned MAX_BYTES = 128
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic [bft_pkg::InDataW-1:0]           in_data_i,    // byte_a, byte_b
  input  logic                                  in_last_i,    // last_byte
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic [bft_pkg::OutDataW-1:0]          out_data_i,   // similarity, common_bits, pad
  input  logic                                  out_user_i,   // empty_pair
  output int unsigned                           fail_count_o,
  output int unsigned                           pending_o
);

  localparam int unsigned BitCap    = (8 * MAX_BYTES < bft_pkg::CntMax) ? 8 * MAX_BYTES
                                                                        : bft_pkg::CntMax;
  localparam int unsigned ReportMax = 10;

  typedef struct {
    logic [bft_pkg::SimW-1:0] ratio;
    logic [bft_pkg::CntW-1:0] common;
    logic                     empty;
  } tanimoto_t;

  logic [bft_pkg::CntW-1:0]    both_acc   = '0;
  logic [bft_pkg::CntW-1:0]    first_acc  = '0;
  logic [bft_pkg::CntW-1:0]    second_acc = '0;
  tanimoto_t                   ratio_queue[$];

  logic [bft_pkg::SimW-1:0]    got_sim;
  logic [bft_pkg::CntW-1:0]    got_common;
  logic [bft_pkg::OutPadW-1:0] got_pad;

  assign got_sim    = out_data_i[bft_pkg::SimW-1:0];
  assign got_common = out_data_i[bft_pkg::SimW +: bft_pkg::CntW];
  assign got_pad    = out_data_i[bft_pkg::OutDataW-1 -: bft_pkg::OutPadW];

  function automatic logic [bft_pkg::CntW-1:0] add_sat(input logic [bft_pkg::CntW-1:0] acc,
                                                       input int unsigned ones);
    int unsigned sum;
    sum = acc + ones;
    return (sum > BitCap) ? bft_pkg::CntW'(BitCap) : bft_pkg::CntW'(sum);
  endfunction

  // Accumulate one byte pair; on the last byte queue the expected ratio and clear.
  task automatic fold_pair(input logic [bft_pkg::ByteW-1:0] a,
                           input logic [bft_pkg::ByteW-1:0] b,
                           input logic last);
    tanimoto_t                res;
    logic [bft_pkg::UniW-1:0] uni;
    longint unsigned          num;
    both_acc   = add_sat(both_acc, $countones(a & b));
    first_acc  = add_sat(first_acc, $countones(a));
    second_acc = add_sat(second_acc, $countones(b));
    if (last) begin
      uni        = first_acc + second_acc - both_acc;
      num        = longint'(both_acc) << 16;
      res.common = both_acc;
      res.empty  = (uni == '0);
      res.ratio  = res.empty ? '0 : bft_pkg::SimW'(num / uni);
      ratio_queue.push_back(res);
      both_acc   = '0;
      first_acc  = '0;
      second_acc = '0;
    end
  endtask

  always @(posedge clk_i) begin
    tanimoto_t want;
    if (!rst_ni) begin
      both_acc   = '0;
      first_acc  = '0;
      second_acc = '0;
      ratio_queue.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (ratio_queue.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportMax)
            $display("%t: result with nothing expected: sim %0d common %0d empty %0b",
                     $realtime, got_sim, got_common, out_user_i);
        end else begin
          want = ratio_queue.pop_front();
          if (got_sim !== want.ratio || got_common !== want.common ||
              got_pad !== '0 || out_user_i !== want.empty) begin
            fail_count_o++;
            if (fail_count_o <= ReportMax)
              $display({"%t: mismatch: expected sim %0d common %0d empty %0b pad 0,",
                        " got sim %0d common %0d empty %0b pad %0h"},
                       $realtime, want.ratio, want.common, want.empty,
                       got_sim, got_common, out_user_i, got_pad);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        fold_pair(in_data_i[bft_pkg::ByteW-1:0], in_data_i[bft_pkg::ByteW +: bft_pkg::ByteW],
                  in_last_i);
    end
    pending_o = ratio_queue.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: streams fingerprint byte pairs into the Tanimoto block and gives the verdict.
module tb_top;

  localparam int unsigned MaxBytes    = 128;
  localparam int unsigned HoldLen     = 300;   // long receiver hold-off, in cycles
  localparam int unsigned StallLimit  = 5000;  // cycles without any transfer before giving up
  localparam int unsigned DrainCycles = 40;    // settling time after the last result, in cycles

  // Content styles for one fingerprint pair.
  typedef enum int unsigned {
    FP_RANDOM,
    FP_SPARSE,
    FP_SAME,
    FP_DISJOINT,
    FP_EMPTY
  } fp_kind_e;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [bft_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         s_axis_tlast  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [bft_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned pairs_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  always #1 clk_i = ~clk_i;

  bit_fingerprint_tanimoto #(
    .MAX_BYTES(MaxBytes)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  bft_tanimoto_checker #(
    .MAX_BYTES(MaxBytes)
  ) u_ratio_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Result side: random back-pressure at the falling edge. A new hold-off
  // request parks tready low for HoldLen cycles, counted here, so the block
  // backs up into its queue while the sender keeps offering bytes.
  always @(negedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HoldLen;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: give up when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("bit_fingerprint_tanimoto regression: fail");
        $finish;
      end
    end
  end

  // Offer one byte pair, starting and ending at a falling edge. Idle cycles
  // come first, with junk on the data lines to make sure it is ignored.
  // Drop tvalid after the transfer so a paused sender offers nothing.
  task automatic push_pair(input logic [bft_pkg::ByteW-1:0] a,
                           input logic [bft_pkg::ByteW-1:0] b,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = bft_pkg::InDataW'($urandom);
      s_axis_tlast  = 1'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {b, a};
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    pairs_sent++;
  endtask

  // Same byte pair repeated over the whole fingerprint, tlast on the final one.
  task automatic send_constant(input int unsigned len, input logic [bft_pkg::ByteW-1:0] a,
                               input logic [bft_pkg::ByteW-1:0] b);
    for (int unsigned i = 0; i < len; i++)
      push_pair(a, b, i == len - 1);
  endtask

  task automatic send_fingerprint(input int unsigned len, input fp_kind_e kind);
    logic [bft_pkg::ByteW-1:0] a;
    logic [bft_pkg::ByteW-1:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      a = bft_pkg::ByteW'($urandom);
      b = bft_pkg::ByteW'($urandom);
      case (kind)
        FP_SPARSE: begin
          a = a & bft_pkg::ByteW'($urandom) & bft_pkg::ByteW'($urandom);
          b = b & bft_pkg::ByteW'($urandom) & bft_pkg::ByteW'($urandom);
        end
        FP_SAME: begin
          // Mostly identical, now and then one bit apart.
          b = ($urandom_range(3) == 0)
              ? a ^ (bft_pkg::ByteW'(1) << $urandom_range(bft_pkg::ByteW - 1)) : a;
        end
        FP_DISJOINT: begin
          b = ~a & b;
        end
        FP_EMPTY: begin
          a = '0;
          b = '0;
        end
        default: ;
      endcase
      push_pair(a, b, i == len - 1);
    end
  endtask

  // Mostly short fingerprints so the divider is kept busy, a few longer.
  task automatic random_until(input int unsigned goal);
    int unsigned len;
    while (pairs_sent < goal) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(32, 9);
      send_fingerprint(len, fp_kind_e'($urandom_range(FP_EMPTY)));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Phase one: sender idles lightly, receiver stalls often.
    send_idle_pct = 20;
    recv_idle_pct = 53;

    // Single-byte fingerprints at the extremes.
    send_constant(1, 8'hFF, 8'hFF);   // identical, full ratio
    send_constant(1, 8'h00, 8'h00);   // both empty
    send_constant(1, 8'hFF, 8'h00);   // second empty only
    send_constant(1, 8'h00, 8'hFF);   // first empty only
    send_constant(1, 8'hAA, 8'h55);   // no common bit
    send_constant(1, 8'hF0, 8'hFF);   // exactly one half
    send_constant(1, 8'h01, 8'h7F);   // one seventh, truncated
    // Multi-byte pairs: a ratio of two thirds, then an all-zero run.
    push_pair(8'h01, 8'h03, 1'b0);
    push_pair(8'h80, 8'h80, 1'b1);
    send_constant(3, 8'h00, 8'h00);
    // Overlong fingerprints drive the counts into saturation.
    send_constant(130, 8'hFF, 8'hFF);
    send_constant(134, 8'hFF, 8'h0F);
    random_until(330);

    // Hold the sender until every result is out, then swap the idle rates.
    wait (pending == 0);
    send_idle_pct = 53;
    recv_idle_pct = 20;
    random_until(500);

    // No idling: stall the receiver for a long stretch while a burst of
    // one-byte fingerprints fills the queue, then run at full rate.
    wait (pending == 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (int unsigned n = 0; n < 30; n++)
      send_fingerprint(1, fp_kind_e'($urandom_range(FP_EMPTY)));
    random_until(650);

    s_axis_tvalid = 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("bit_fingerprint_tanimoto regression: pass");
    end else begin
      $display("bit_fingerprint_tanimoto regression: fail");
    end
    $finish;
  end

endmodule
